### hw/rtl/pol_pkg.sv
`default_nettype none

package pol_pkg;

  // List geometry
  localparam int DEPTH    = 16;
  localparam int HANDLE_W = 32;

  // Transaction field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 5;

  // Internal widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_TAIL = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_AT   = 3'd2,
    REQ_REM_VAL  = 3'd3,
    REQ_REM_AT   = 3'd4,
    REQ_GET      = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTFND  = 2'd2,
    ST_BADPOS  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             apply;
    op_t              op;
    logic [IDX_W-1:0] idx;
    stat_t            status;
  } pol_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic             pos_zero;
    logic             pos_gt_cnt;
    logic             pos_past_end;
    logic             full;
    logic             empty;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             out_free;
  } pol_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pol_req_if.sv
`default_nettype none

interface pol_req_if;
  logic                        valid;
  logic                        ready;
  logic [pol_pkg::REQ_W-1:0]   req_type;
  logic [pol_pkg::POS_W-1:0]   position;
  logic [pol_pkg::VAL_W-1:0]   value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

`default_nettype wire

### hw/rtl/pol_rsp_if.sv
`default_nettype none

interface pol_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pol_pkg::STAT_W-1:0]  status;
  logic [pol_pkg::VAL_W-1:0]   read_value;
  logic [pol_pkg::ECNT_W-1:0]  entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/pol_ctrl.sv
`default_nettype none

module pol_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pol_pkg::pol_stat_t st,
  output pol_pkg::pol_cmd_t       cmd
);
  import pol_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [POS_W-1:0] pos_m1;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a request, then apply it once the result register is free
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pos_m1 = st.pos - POS_W'(1);

  // Outputs: decode the held request into an edit command
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.apply  = (state_r == S_APPLY) && st.out_free;
    cmd.op     = OP_NONE;
    cmd.idx    = '0;
    cmd.status = ST_OK;
    unique case (st.req)
      REQ_INS_TAIL: begin
        if (st.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op  = OP_INS;
          cmd.idx = IDX_W'(st.count);
        end
      end
      REQ_INS_HEAD: begin
        if (st.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op = OP_INS;
        end
      end
      REQ_INS_AT: begin
        priority if (st.pos_zero) begin
          cmd.status = ST_BADPOS;
        end else if (st.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op  = OP_INS;
          cmd.idx = st.pos_past_end ? IDX_W'(st.count) : IDX_W'(pos_m1);
        end
      end
      REQ_REM_VAL: begin
        if (!st.hit) begin
          cmd.status = ST_NOTFND;
        end else begin
          cmd.op  = OP_REM;
          cmd.idx = st.hit_idx;
        end
      end
      REQ_REM_AT, REQ_GET: begin
        priority if (st.empty) begin
          cmd.status = ST_NOTFND;
        end else if (st.pos_zero || st.pos_gt_cnt) begin
          cmd.status = ST_BADPOS;
        end else begin
          cmd.op  = (st.req == REQ_GET) ? OP_READ : OP_REM;
          cmd.idx = IDX_W'(pos_m1);
        end
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/pol_dpath.sv
`default_nettype none

module pol_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pol_req_if.sink                in_ch,
  pol_rsp_if.source              out_ch,
  input  wire pol_pkg::pol_cmd_t cmd,
  output pol_pkg::pol_stat_t     st
);
  import pol_pkg::*;

  logic [HANDLE_W-1:0] cells_r   [DEPTH];
  logic [HANDLE_W-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [POS_W-1:0]    pos_r;
  logic [HANDLE_W-1:0] val_r;
  logic [DEPTH-1:0]    match_r;
  logic [DEPTH-1:0]    match_nxt;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [VAL_W-1:0]    out_rdata_r;
  logic [ECNT_W-1:0]   out_count_r;
  logic [HANDLE_W-1:0] sel_cell;
  logic [IDX_W-1:0]    hit_idx;
  logic [HANDLE_W-1:0] in_val;

  assign in_val = HANDLE_W'(in_ch.value);

  // Compare the incoming value against every occupied cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (cells_r[i] == in_val) && (CNT_W'(i) < count_r);
    end
  end

  // Lowest matching cell wins
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
    end
  end

  // Shift cells open for an insert, closed for a removal
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (cmd.op == OP_INS) begin
        if (IDX_W'(i) == cmd.idx) begin
          cells_nxt[i] = val_r;
        end else if ((i > 0) && (IDX_W'(i) > cmd.idx)) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.op == OP_REM) begin
        if ((i < DEPTH - 1) && (IDX_W'(i) >= cmd.idx)) begin
          cells_nxt[i] = cells_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign sel_cell = cells_r[cmd.idx];

  always_comb begin
    unique case (cmd.op)
      OP_INS:  count_nxt = count_r + CNT_W'(1);
      OP_REM:  count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Control state: entry count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request and its match vector
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_ch.req_type;
      pos_r   <= in_ch.position;
      val_r   <= in_val;
      match_r <= match_nxt;
    end
  end

  // Commit the edit and load the result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      out_status_r <= cmd.status;
      out_rdata_r  <= ((cmd.op == OP_REM) || (cmd.op == OP_READ)) ? VAL_W'(sel_cell) : '0;
      out_count_r  <= ECNT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_rdata_r;
  assign out_ch.entry_count = out_count_r;

  // Status towards the controller
  always_comb begin
    st.req          = req_r;
    st.pos          = pos_r;
    st.count        = count_r;
    st.pos_zero     = (pos_r == '0);
    st.pos_gt_cnt   = CMP_W'(pos_r) > CMP_W'(count_r);
    st.pos_past_end = CMP_W'(pos_r) > (CMP_W'(count_r) + CMP_W'(1));
    st.full         = (count_r == CNT_W'(DEPTH));
    st.empty        = (count_r == '0);
    st.hit          = |match_r;
    st.hit_idx      = hit_idx;
    st.out_free     = !out_valid_r || out_ch.ready;
  end

endmodule

`default_nettype wire

### hw/rtl/positional_ordered_list_unit.sv
`default_nettype none

// Bounded ordered list of up to 16 handle words, position 1 at the head.
// A request inserts (tail, head or position), removes (by value or by
// position) or reads by position, and returns one result carrying a status,
// the value read or removed (zero otherwise) and the entry count after the
// request. Inserting past the end appends. Each request is first captured
// and its value compared against all cells in parallel; then the cells are
// shifted and the result register loaded, a step that waits while an earlier
// result is still held on the output. A new request is
// taken while the previous result waits to be collected. No clearing pass
// follows reset: the list is empty as soon as reset is released.
module positional_ordered_list_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  pol_req_if.sink   in_ch,
  pol_rsp_if.source out_ch
);
  import pol_pkg::*;

  pol_cmd_t  cmd;
  pol_stat_t st;
  logic      ctl_ready;

  pol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pol_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .st     (st)
  );

  assign in_ch.ready = ctl_ready;

  // Entry count stays within the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(st.count) <= CMP_W'(DEPTH))
    else $error("entry count beyond depth");

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in flight");

  // Count moves by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (st.count != $past(st.count))) |->
      ((CMP_W'(st.count) == CMP_W'($past(st.count)) + CMP_W'(1)) ||
       (CMP_W'(st.count) + CMP_W'(1) == CMP_W'($past(st.count)))))
    else $error("entry count jumped");

  // A failed request returns no value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.read_value == '0))
    else $error("nonzero value on failed request");

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  // Request codes the block does not decode; they must leave the list alone
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    stat_t             status;
    logic [VAL_W-1:0]  read_value;
    logic [ECNT_W-1:0] entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  pol_req_if req_bus ();
  pol_rsp_if rsp_bus ();

  positional_ordered_list_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus)
  );

  // Mirror of the list contents, head at index 0
  logic [HANDLE_W-1:0] list_model[$];
  list_result_t        pending_results[$];
  list_result_t        want;

  int  error_count = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  int  stall_roll;
  bit  burst_mode  = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the result of one accepted request and update the mirror
  function automatic void apply_list_request(input logic [REQ_W-1:0] rq,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
    list_result_t r;
    int           n;
    int           p;
    int           hit;
    n = list_model.size();
    p = pos;
    hit = -1;
    r.status = ST_OK;
    r.read_value = '0;
    case (rq)
      REQ_INS_TAIL: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else list_model.push_back(val);
      end
      REQ_INS_HEAD: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else list_model.push_front(val);
      end
      REQ_INS_AT: begin
        // position test comes ahead of the full test
        if (p == 0) r.status = ST_BADPOS;
        else if (n >= DEPTH) r.status = ST_FULL;
        else if (p - 1 >= n) list_model.push_back(val);
        else list_model.insert(p - 1, val);
      end
      REQ_REM_VAL: begin
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && list_model[i] == val) hit = i;
        end
        if (hit < 0) r.status = ST_NOTFND;
        else begin
          r.read_value = list_model[hit];
          list_model.delete(hit);
        end
      end
      REQ_REM_AT, REQ_GET: begin
        if (n == 0) r.status = ST_NOTFND;
        else if (p == 0 || p > n) r.status = ST_BADPOS;
        else begin
          r.read_value = list_model[p - 1];
          if (rq == REQ_REM_AT) list_model.delete(p - 1);
        end
      end
      default: ;
    endcase
    r.entry_count = ECNT_W'(list_model.size());
    pending_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one request and hold it until the block takes it; valid stays high on return
  task automatic send_req(input logic [REQ_W-1:0] rq, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= rq;
    req_bus.position <= pos;
    req_bus.value    <= val;
    do @(posedge clk); while (!req_bus.ready);
    apply_list_request(rq, pos, val);
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One random request, weighted towards inserts or removals by the caller
  task automatic send_random(input int ins_pct, input int rem_pct);
    int               r;
    int               n;
    logic [REQ_W-1:0] rq;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    n = list_model.size();
    r = $urandom_range(99);
    if (r < ins_pct) begin
      case ($urandom_range(2))
        0:       rq = REQ_INS_TAIL;
        1:       rq = REQ_INS_HEAD;
        default: rq = REQ_INS_AT;
      endcase
    end else if (r < ins_pct + rem_pct) begin
      rq = $urandom_range(1) ? REQ_REM_AT : REQ_REM_VAL;
    end else if (r < 97) begin
      rq = REQ_GET;
    end else begin
      rq = $urandom_range(1) ? REQ_RSVD7 : REQ_RSVD6;
    end
    // mostly positions in or just past the list, now and then zero or anything
    r = $urandom_range(9);
    if (r < 8) pos = POS_W'($urandom_range(n + 1, 1));
    else if (r == 8) pos = '0;
    else pos = POS_W'($urandom());
    // removals by value usually target a live entry; small values give duplicates
    r = $urandom_range(99);
    if (rq == REQ_REM_VAL && n > 0 && r < 70) val = list_model[$urandom_range(n - 1)];
    else if (r < 85) val = VAL_W'($urandom_range(7));
    else val = VAL_W'($urandom());
    send_req(rq, pos, val);
  endtask

  // Empty list, every request code, position edges and value extremes
  task automatic test_directed();
    send_req(REQ_GET,      5'd1,  32'h0000_0000);
    send_req(REQ_REM_AT,   5'd1,  32'h0000_0000);
    send_req(REQ_REM_VAL,  5'd0,  32'h0000_0000);
    send_req(REQ_INS_TAIL, 5'd0,  32'h0000_0000);
    send_req(REQ_INS_HEAD, 5'd31, 32'hFFFF_FFFF);
    send_req(REQ_INS_AT,   5'd0,  32'h5555_AAAA);
    send_req(REQ_INS_AT,   5'd2,  32'hA5A5_5A5A);
    send_req(REQ_INS_AT,   5'd31, 32'h1234_5678);
    send_req(REQ_INS_AT,   5'd5,  32'h0000_0001);
    send_req(REQ_INS_TAIL, 5'd0,  32'hA5A5_5A5A);
    send_req(REQ_GET,      5'd0,  32'h0000_0000);
    send_req(REQ_GET,      5'd7,  32'h0000_0000);
    send_req(REQ_GET,      5'd31, 32'h0000_0000);
    send_req(REQ_GET,      5'd6,  32'h0000_0000);
    send_req(REQ_GET,      5'd1,  32'h0000_0000);
    send_req(REQ_REM_VAL,  5'd0,  32'hA5A5_5A5A);
    send_req(REQ_REM_VAL,  5'd0,  32'hDEAD_BEEF);
    send_req(REQ_REM_AT,   5'd0,  32'h0000_0000);
    send_req(REQ_REM_AT,   5'd6,  32'h0000_0000);
    send_req(REQ_REM_AT,   5'd5,  32'h0000_0000);
    send_req(REQ_REM_AT,   5'd1,  32'h0000_0000);
    send_req(REQ_RSVD6,    5'd3,  32'hFFFF_FFFF);
    send_req(REQ_RSVD7,    5'd31, 32'h0000_0000);
    send_req(REQ_REM_VAL,  5'd16, 32'h0000_0000);
    wait_drained();
  endtask

  // Insert-heavy run: reaches a full list and keeps pushing against it
  task automatic test_random_grow();
    repeat (120) send_random(75, 15);
    wait_drained();
  endtask

  // Balanced traffic back to back on both sides
  task automatic test_random_churn();
    burst_mode = 1'b1;
    repeat (150) send_random(40, 40);
    wait_drained();
    burst_mode = 1'b0;
  endtask

  // Removal-heavy run: drains the list and keeps hitting the empty cases
  task automatic test_random_shrink();
    repeat (100) send_random(15, 70);
    wait_drained();
  endtask

  task automatic test_random_mixed();
    repeat (130) send_random(45, 35);
    wait_drained();
  endtask

  // Main sequence
  initial begin
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= '0;
    req_bus.position <= '0;
    req_bus.value    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_grow();
    test_random_churn();
    test_random_shrink();
    test_random_mixed();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Check each result transaction against the oldest expectation, then pick next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t unexpected result: status %0d value %h count %0d", $realtime,
                     rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.status !== want.status || rsp_bus.read_value !== want.read_value ||
              rsp_bus.entry_count !== want.entry_count) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                       $realtime, want.status, want.read_value, want.entry_count,
                       rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
          end
        end
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (burst_mode) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        stall_roll = $urandom_range(99);
        if (stall_roll < 65) begin
          rsp_bus.ready <= 1'b1;
        end else if (stall_roll < 95) begin
          rsp_bus.ready <= 1'b0;
          stall_left    <= $urandom_range(2);
        end else begin
          rsp_bus.ready <= 1'b0;
          stall_left    <= $urandom_range(40, 8);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
